/* sv/mcrt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrt_pkg
// Shared types and constants of the March C- RAM test engine.
// ----------------------------------------------------------------------------
package mcrt_pkg;

   localparam int ADDR_W     = 30;
   localparam int DATA_W     = 32;
   localparam int WCFG_W     = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 30;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_TEST_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEST_WORDS = 1'b1;

   localparam logic [WCFG_W-1:0] TEST_WORDS_RST = 9'd256;

   localparam logic [DATA_W-1:0] PAT_ZEROS = 32'h0000_0000;
   localparam logic [DATA_W-1:0] PAT_ONES  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic              start_req;
      logic [DATA_W-1:0] read_data;
   } req_type;

   typedef struct packed {
      logic              access_valid;
      logic [ADDR_W-1:0] mem_address;
      logic              write_enable;
      logic [DATA_W-1:0] write_data;
      logic              busy_res;
      logic              done_res;
      logic              failed;
   } rsp_type;

endpackage

/* sv/mcrt_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrt_req_if
// Request channel: start and read data, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcrt_req_if;
   logic              valid;
   logic              ready;
   mcrt_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* sv/mcrt_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrt_rsp_if
// Response channel: one memory access and status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcrt_rsp_if;
   logic              valid;
   logic              ready;
   mcrt_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* sv/mcrt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcrt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mcrt_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrt_step
// Sequencer state, configuration registers and the per-beat step logic.
// ----------------------------------------------------------------------------
module mcrt_step #(
   parameter int WORDS = 256
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        accept,
   input  mcrt_pkg::req_type                           req,
   output mcrt_pkg::rsp_type                           rsp,
   input  logic                                        csr_we,
   input  logic [mcrt_pkg::CSR_IDX_W-1:0]              csr_index,
   input  logic [mcrt_pkg::CSR_DATA_W-1:0]             csr_wdata,
   output logic                                        bk_we,
   output logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] bk_waddr,
   output logic [mcrt_pkg::DATA_W-1:0]                 bk_wdata,
   output logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] bk_raddr,
   input  logic [mcrt_pkg::DATA_W-1:0]                 bk_rdata
);
   import mcrt_pkg::*;

   localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CNT_W = $clog2(WORDS + 1);
   localparam int CMP_W = (CNT_W > WCFG_W) ? CNT_W : WCFG_W;
   localparam int PH_W  = 4;

   localparam logic [PH_W-1:0] PH_IDLE    = 4'd0;
   localparam logic [PH_W-1:0] PH_BACKUP  = 4'd1;
   localparam logic [PH_W-1:0] PH_W0      = 4'd2;
   localparam logic [PH_W-1:0] PH_UP_R0W1 = 4'd3;
   localparam logic [PH_W-1:0] PH_UP_R1W0 = 4'd4;
   localparam logic [PH_W-1:0] PH_DN_R0W1 = 4'd5;
   localparam logic [PH_W-1:0] PH_DN_R1W0 = 4'd6;
   localparam logic [PH_W-1:0] PH_R0      = 4'd7;
   localparam logic [PH_W-1:0] PH_RESTORE = 4'd8;

   logic [ADDR_W-1:0] base_ff;
   logic [WCFG_W-1:0] words_ff;
   logic [PH_W-1:0]   phase_ff, phase_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              await_ff, await_in;
   logic              fail_ff, fail_in;
   logic [DATA_W-1:0] word0_ff;

   logic [CMP_W-1:0]  words_ext, cnt_wide;
   logic [IDX_W-1:0]  last_idx;
   logic              do_wr;
   logic [DATA_W-1:0] expect_pat;
   logic [PH_W+IDX_W-1:0] pos;

   function automatic logic is_down(input logic [PH_W-1:0] p);
      return (p == PH_DN_R0W1) || (p == PH_DN_R1W0);
   endfunction

   function automatic logic [DATA_W-1:0] expect_of(input logic [PH_W-1:0] p);
      return ((p == PH_UP_R1W0) || (p == PH_DN_R1W0)) ? PAT_ONES : PAT_ZEROS;
   endfunction

   // step past the current word; at the end of an element enter the next one
   function automatic logic [PH_W+IDX_W-1:0] advance(input logic [PH_W-1:0]  p,
                                                      input logic [IDX_W-1:0] i,
                                                      input logic [IDX_W-1:0] last);
      logic [PH_W-1:0]  p_n;
      logic [IDX_W-1:0] i_n;
      logic             wrap;
      wrap = is_down(p) ? (i == '0) : (i == last);
      p_n  = p;
      i_n  = is_down(p) ? i - 1'b1 : i + 1'b1;
      if (wrap) begin
         p_n = p + 1'b1;
         i_n = is_down(p + 1'b1) ? last : '0;
      end
      return {p_n, i_n};
   endfunction

   // effective word count: 0 acts as 1, above WORDS acts as WORDS
   assign words_ext = CMP_W'(words_ff);
   always_comb begin
      if (words_ext == '0) begin
         cnt_wide = CMP_W'(1);
      end else if (words_ext > CMP_W'(WORDS)) begin
         cnt_wide = CMP_W'(WORDS);
      end else begin
         cnt_wide = words_ext;
      end
   end
   assign last_idx = IDX_W'(cnt_wide - CMP_W'(1));

   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      await_in   = await_ff;
      fail_in    = fail_ff;
      rsp        = '0;
      bk_we      = 1'b0;
      bk_waddr   = idx_ff;
      bk_wdata   = req.read_data;
      do_wr      = 1'b0;
      expect_pat = PAT_ZEROS;
      pos        = '0;

      if (phase_ff != PH_IDLE || req.start_req) begin
         if (phase_ff == PH_IDLE) begin
            fail_in  = 1'b0;
            await_in = 1'b0;
            phase_in = PH_BACKUP;
            idx_in   = '0;
         end

         if (await_in) begin
            await_in   = 1'b0;
            expect_pat = expect_of(phase_in);
            if (phase_in == PH_BACKUP) begin
               bk_we = 1'b1;
               if (idx_in == last_idx) begin
                  phase_in = PH_W0;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_in + 1'b1;
               end
            end else if (phase_in >= PH_UP_R0W1 && phase_in <= PH_R0) begin
               if (req.read_data != expect_pat) begin
                  fail_in  = 1'b1;
                  phase_in = PH_RESTORE;
                  idx_in   = '0;
               end else if (phase_in == PH_R0) begin
                  pos      = advance(phase_in, idx_in, last_idx);
                  phase_in = pos[PH_W+IDX_W-1:IDX_W];
                  idx_in   = pos[IDX_W-1:0];
               end else begin
                  do_wr = 1'b1;
               end
            end
         end

         rsp.access_valid = 1'b1;
         rsp.busy_res     = 1'b1;
         rsp.mem_address  = base_ff + ADDR_W'(idx_in);

         if (do_wr || phase_in == PH_W0) begin
            rsp.write_enable = 1'b1;
            rsp.write_data   = do_wr ? ~expect_pat : PAT_ZEROS;
            pos      = advance(phase_in, idx_in, last_idx);
            phase_in = pos[PH_W+IDX_W-1:IDX_W];
            idx_in   = pos[IDX_W-1:0];
         end else if (phase_in == PH_RESTORE) begin
            rsp.write_enable = 1'b1;
            // word 0 is needed on the entry beat, before the RAM can be read
            rsp.write_data   = (idx_in == '0) ? word0_ff : bk_rdata;
            if (idx_in == last_idx) begin
               rsp.done_res = 1'b1;
               rsp.failed   = fail_in;
               phase_in     = PH_IDLE;
               idx_in       = '0;
            end else begin
               idx_in = idx_in + 1'b1;
            end
         end else begin
            await_in = 1'b1;
         end
      end
   end

   // read ahead so that the RAM presents backup[idx_ff] on the next beat
   assign bk_raddr = accept ? idx_in : idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         idx_ff   <= '0;
         await_ff <= 1'b0;
         fail_ff  <= 1'b0;
         base_ff  <= '0;
         words_ff <= TEST_WORDS_RST;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            idx_ff   <= idx_in;
            await_ff <= await_in;
            fail_ff  <= fail_in;
         end
         if (csr_we && phase_ff == PH_IDLE) begin
            unique case (csr_index)
               CSR_TEST_BASE: begin
                  base_ff <= csr_wdata[ADDR_W-1:0];
               end
               CSR_TEST_WORDS: begin
                  words_ff <= csr_wdata[WCFG_W-1:0];
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && bk_we && bk_waddr == '0) begin
         word0_ff <= req.read_data;
      end
   end

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> idx_ff == '0 && !await_ff)
      else $error("idle sequencer holds a word index or a pending read");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> idx_ff <= last_idx)
      else $error("word index beyond the tested region");

   a_restore_no_read: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_RESTORE |-> !await_ff)
      else $error("read pending during restore");

endmodule

/* sv/mcrt_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrt_out_buf
// Two-entry output register with skid stage for the response channel.
// ----------------------------------------------------------------------------
module mcrt_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mcrt_pkg::rsp_type push_data,
   output logic              push_ready,
   mcrt_rsp_if.source        rsp_chan
);
   import mcrt_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   assign pop        = out_valid_ff && rsp_chan.ready;
   assign push_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (push) begin
         if (out_valid_in) begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end else begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      push && out_valid_ff && !rsp_chan.ready |=> skid_valid_ff)
      else $error("beat pushed into a stalled output was dropped");

endmodule

/* sv/march_c_ram_test_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// march_c_ram_test_engine_core
// March C- memory test sequencer with backup and restore of the tested region.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one beat per step: start_req and the read data that
//   answers the read issued on the previous step. Every accepted request
//   beat yields exactly one rsp_chan beat: a memory access (address, write
//   enable, write data) plus busy, done and failed status; an idle beat
//   without start gives an all-zero response.
//   Each response beat is registered in the output buffer; one beat is
//   accepted every cycle while that buffer has room for it.
//   A test of N words takes N backup beats, 10N March beats and N restore
//   beats when it passes; the first mismatch jumps straight to restore.
//   The backup store is a WORDS-deep RAM, read one beat ahead of restore.
//   csr_we/csr_index/csr_wdata write test_base (0) and test_words (1); writes
//   are taken only while no test runs.
//   Reset returns the sequencer to idle and the registers to base 0 and
//   256 words; the backup RAM is not cleared and needs no pass.
//   When the receiver stalls, a two-entry output buffer keeps taking beats;
//   req_chan.ready drops only once both entries hold a response.
// ----------------------------------------------------------------------------
module march_c_ram_test_engine_core #(
   parameter int WORDS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   mcrt_req_if.sink                        req_chan,
   mcrt_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [mcrt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mcrt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mcrt_pkg::*;

   localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic              accept;
   logic              buf_ready;
   rsp_type           step_rsp;
   logic              bk_we;
   logic [IDX_W-1:0]  bk_waddr;
   logic [DATA_W-1:0] bk_wdata;
   logic [IDX_W-1:0]  bk_raddr;
   logic [DATA_W-1:0] bk_rdata;

   assign req_chan.ready = buf_ready;
   assign accept         = req_chan.valid && buf_ready;

   mcrt_step #(
      .WORDS (WORDS)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_chan.payload),
      .rsp       (step_rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .bk_we     (bk_we),
      .bk_waddr  (bk_waddr),
      .bk_wdata  (bk_wdata),
      .bk_raddr  (bk_raddr),
      .bk_rdata  (bk_rdata)
   );

   mcrt_ram #(
      .WIDTH (DATA_W),
      .DEPTH (WORDS)
   ) u_backup (
      .clock   (clock),
      .wr_en   (accept && bk_we),
      .wr_addr (bk_waddr),
      .wr_data (bk_wdata),
      .rd_addr (bk_raddr),
      .rd_data (bk_rdata)
   );

   mcrt_out_buf u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (step_rsp),
      .push_ready (buf_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Runs the March C- engine against a behavioral RAM that answers every read
// of the block, with random data and injected read faults. A step-accurate
// model of the sequencer predicts each response beat, and the monitor checks
// it field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import mcrt_pkg::*;

   localparam int WORDS          = 256;
   localparam int ITEM_BUDGET    = 1800;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_PRINTED    = 40;
   localparam int LONG_STALL     = 90;

   // two copies of the sequencer model: one plans the stimulus, one checks
   localparam int PLAN  = 0;
   localparam int CHECK = 1;

   typedef enum logic [3:0] {
      PH_IDLE, PH_BACKUP, PH_W0, PH_UP_R0W1, PH_UP_R1W0,
      PH_DN_R0W1, PH_DN_R1W0, PH_R0, PH_RESTORE
   } march_phase_t;

   typedef enum logic [2:0] {
      RX_ALWAYS, RX_MOSTLY, RX_HALF, RX_RARE, RX_PERIODIC
   } rx_mode_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid   = 1'b0;
   req_type               req_payload = '0;
   logic                  rsp_ready   = 1'b0;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   mcrt_req_if req_if ();
   mcrt_rsp_if rsp_if ();

   assign req_if.valid   = req_valid;
   assign req_if.payload = req_payload;
   assign rsp_if.ready   = rsp_ready;

   march_c_ram_test_engine_core #(.WORDS(WORDS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // sequencer model state, one set per copy
   march_phase_t      ph_q      [2];
   logic [8:0]        idx_q     [2];
   logic              rd_pend_q [2];
   logic              fail_q    [2];
   logic [ADDR_W-1:0] base_q    [2];
   logic [WCFG_W-1:0] words_q   [2];
   logic [DATA_W-1:0] backup_q  [2][WORDS];

   req_type           req_backlog[$];
   rsp_type           expected_access_q[$];
   logic [DATA_W-1:0] ram_model[logic [ADDR_W-1:0]];
   logic [ADDR_W-1:0] last_read_addr;

   int items_queued  = 0;
   int req_beats     = 0;
   int beats_total   = 0;
   int rsp_checked   = 0;
   int tests_done    = 0;
   int tests_flagged = 0;
   int mismatches    = 0;

   // ------------------------------------------------------------------------
   // sequencer model
   // ------------------------------------------------------------------------
   function automatic logic [8:0] eff_words(int cp);
      logic [8:0] n;
      n = words_q[cp];
      if (n == 0) n = 9'd1;
      if (n > WORDS) n = 9'(WORDS);
      return n;
   endfunction

   function automatic logic elem_is_rw(march_phase_t ph);
      return ph >= PH_UP_R0W1 && ph <= PH_DN_R1W0;
   endfunction

   function automatic logic elem_is_down(march_phase_t ph);
      return ph == PH_DN_R0W1 || ph == PH_DN_R1W0;
   endfunction

   function automatic logic [DATA_W-1:0] read_pattern(march_phase_t ph);
      return (ph == PH_UP_R1W0 || ph == PH_DN_R1W0) ? PAT_ONES : PAT_ZEROS;
   endfunction

   function automatic void enter_elem(int cp, march_phase_t ph, logic [8:0] n);
      ph_q[cp]  = ph;
      idx_q[cp] = elem_is_down(ph) ? n - 9'd1 : 9'd0;
   endfunction

   function automatic void next_word(int cp, logic [8:0] n);
      if (elem_is_down(ph_q[cp])) begin
         if (idx_q[cp] == 0) enter_elem(cp, march_phase_t'(ph_q[cp] + 4'd1), n);
         else idx_q[cp] = idx_q[cp] - 9'd1;
      end else begin
         idx_q[cp] = idx_q[cp] + 9'd1;
         if (idx_q[cp] >= n) enter_elem(cp, march_phase_t'(ph_q[cp] + 4'd1), n);
      end
   endfunction

   // one step of the sequencer: takes a request beat, gives its response
   function automatic rsp_type march_step(int cp, req_type rq);
      rsp_type    r;
      logic [8:0] n;
      logic       wr_back;
      r       = '0;
      n       = eff_words(cp);
      wr_back = 1'b0;

      if (ph_q[cp] == PH_IDLE) begin
         if (!rq.start_req) return r;
         fail_q[cp]    = 1'b0;
         rd_pend_q[cp] = 1'b0;
         enter_elem(cp, PH_BACKUP, n);
      end

      if (rd_pend_q[cp]) begin
         rd_pend_q[cp] = 1'b0;
         if (ph_q[cp] == PH_BACKUP) begin
            backup_q[cp][idx_q[cp] % WORDS] = rq.read_data;
            idx_q[cp] = idx_q[cp] + 9'd1;
            if (idx_q[cp] >= n) enter_elem(cp, PH_W0, n);
         end else if (elem_is_rw(ph_q[cp]) || ph_q[cp] == PH_R0) begin
            if (rq.read_data != read_pattern(ph_q[cp])) begin
               // first miscompare abandons the march and restores
               fail_q[cp] = 1'b1;
               enter_elem(cp, PH_RESTORE, n);
            end else if (ph_q[cp] == PH_R0) begin
               next_word(cp, n);
            end else begin
               wr_back = 1'b1;
            end
         end
      end

      r.access_valid = 1'b1;
      r.busy_res     = 1'b1;
      r.mem_address  = base_q[cp] + ADDR_W'(idx_q[cp]);

      if (wr_back) begin
         r.write_enable = 1'b1;
         r.write_data   = (read_pattern(ph_q[cp]) == PAT_ZEROS) ? PAT_ONES : PAT_ZEROS;
         next_word(cp, n);
      end else if (ph_q[cp] == PH_W0) begin
         r.write_enable = 1'b1;
         r.write_data   = PAT_ZEROS;
         next_word(cp, n);
      end else if (ph_q[cp] == PH_RESTORE) begin
         r.write_enable = 1'b1;
         r.write_data   = backup_q[cp][idx_q[cp] % WORDS];
         idx_q[cp] = idx_q[cp] + 9'd1;
         if (idx_q[cp] >= n) begin
            r.done_res = 1'b1;
            r.failed   = fail_q[cp];
            ph_q[cp]   = PH_IDLE;
            idx_q[cp]  = 9'd0;
         end
      end else begin
         rd_pend_q[cp] = 1'b1;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [DATA_W-1:0] ram_read(logic [ADDR_W-1:0] a);
      if (!ram_model.exists(a)) ram_model[a] = $urandom;
      return ram_model[a];
   endfunction

   // queue a request beat and let the planning copy follow the block
   task automatic offer(logic start, logic [DATA_W-1:0] data);
      req_type rq;
      rsp_type r;
      rq.start_req = start;
      rq.read_data = data;
      req_backlog.push_back(rq);
      items_queued++;
      r = march_step(PLAN, rq);
      if (r.access_valid) begin
         if (r.write_enable) ram_model[r.mem_address] = r.write_data;
         else last_read_addr = r.mem_address;
      end
   endtask

   // one full test; fault_at picks the compare read to corrupt, 0 for none
   task automatic queue_test(int fault_at);
      int                compares;
      logic [DATA_W-1:0] d;
      compares = 0;
      offer(1'b1, $urandom);
      while (ph_q[PLAN] != PH_IDLE) begin
         if (rd_pend_q[PLAN]) begin
            d = ram_read(last_read_addr);
            if (ph_q[PLAN] != PH_BACKUP) begin
               compares++;
               if (compares == fault_at) begin
                  if ($urandom_range(0, 1) == 0) d = d ^ (32'h1 << $urandom_range(0, 31));
                  else d = $urandom;
               end
            end
         end else begin
            d = $urandom;
         end
         // start while busy should be ignored
         offer($urandom_range(0, 3) == 0, d);
      end
   endtask

   task automatic wait_drained(int extra);
      @(negedge clock);
      while (req_backlog.size() != 0 || expected_access_q.size() != 0 || req_valid)
         @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      int cp;
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      for (cp = 0; cp < 2; cp++) begin
         if (ph_q[cp] == PH_IDLE) begin
            case (idx)
               CSR_TEST_BASE:  base_q[cp]  = val;
               CSR_TEST_WORDS: words_q[cp] = val[WCFG_W-1:0];
               default: ;
            endcase
         end
      end
   endtask

   task automatic retune(logic wr_base, logic [CSR_DATA_W-1:0] base,
                         logic wr_words, logic [CSR_DATA_W-1:0] words_val);
      wait_drained(SETTLE_CYCLES);
      if (wr_base) csr_write(CSR_TEST_BASE, base);
      if (wr_words) csr_write(CSR_TEST_WORDS, words_val);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // driver: bursts of random length with random gaps
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
      end else if (!req_valid || req_if.ready) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (req_backlog.size() != 0) begin
            req_valid   <= 1'b1;
            req_payload <= req_backlog.pop_front();
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(150, 300)
                                                         : $urandom_range(1, 48);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: changing ready pattern plus an occasional long hold-off
   // ------------------------------------------------------------------------
   rx_mode_t rx_mode    = RX_ALWAYS;
   int       rx_cycle   = 0;
   int       stall_left = 0;
   int       stall_mark = 200;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle % 128 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 4));
         if (stall_left != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (req_beats >= stall_mark && req_valid) begin
            // hold off long enough for the block to back up into req_chan
            rsp_ready  <= 1'b0;
            stall_left <= LONG_STALL;
            stall_mark <= stall_mark + 700;
         end else begin
            case (rx_mode)
               RX_ALWAYS:   rsp_ready <= 1'b1;
               RX_MOSTLY:   rsp_ready <= $urandom_range(0, 3) != 0;
               RX_HALF:     rsp_ready <= $urandom_range(0, 1) != 0;
               RX_RARE:     rsp_ready <= $urandom_range(0, 6) == 0;
               RX_PERIODIC: rsp_ready <= (rx_cycle % 7) < 3;
               default:     rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: checks response beats, then predicts for the accepted request
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what);
      if (mismatches < MAX_PRINTED)
         $display("ERROR @%0t response %0d: %s", $realtime, rsp_checked, what);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_ready) begin
            got = rsp_if.payload;
            if (expected_access_q.size() == 0) begin
               report_mismatch($sformatf("beat %h with nothing expected", got));
            end else begin
               want = expected_access_q.pop_front();
               check_field("access_valid", 32'(got.access_valid), 32'(want.access_valid));
               check_field("mem_address",  32'(got.mem_address),  32'(want.mem_address));
               check_field("write_enable", 32'(got.write_enable), 32'(want.write_enable));
               check_field("write_data",   got.write_data,        want.write_data);
               check_field("busy_res",     32'(got.busy_res),     32'(want.busy_res));
               check_field("done_res",     32'(got.done_res),     32'(want.done_res));
               check_field("failed",       32'(got.failed),       32'(want.failed));
            end
            rsp_checked++;
         end
         if (req_valid && req_if.ready) begin
            want = march_step(CHECK, req_payload);
            expected_access_q.push_back(want);
            if (want.done_res) begin
               tests_done++;
               if (want.failed) tests_flagged++;
            end
            req_beats <= req_beats + 1;
         end
         if ((rsp_if.valid && rsp_ready) || (req_valid && req_if.ready))
            beats_total <= beats_total + 1;
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: outstanding work but no beat moving
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      int last_beats;
      quiet      = 0;
      last_beats = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if (beats_total != last_beats ||
             (req_backlog.size() == 0 && expected_access_q.size() == 0 && !req_valid))
            quiet = 0;
         else
            quiet++;
         last_beats = beats_total;
      end
      $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int                    cp;
      int                    fault_at;
      int                    test_no;
      logic                  wr_base;
      logic                  wr_words;
      logic [CSR_DATA_W-1:0] base;
      logic [CSR_DATA_W-1:0] wv;
      logic [WCFG_W-1:0]     cnt;

      for (cp = 0; cp < 2; cp++) begin
         ph_q[cp]      = PH_IDLE;
         idx_q[cp]     = 9'd0;
         rd_pend_q[cp] = 1'b0;
         fail_q[cp]    = 1'b0;
         base_q[cp]    = '0;
         words_q[cp]   = TEST_WORDS_RST;
         for (int i = 0; i < WORDS; i++) backup_q[cp][i] = '0;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // idle beats without start give an empty response
      offer(1'b0, PAT_ZEROS);
      offer(1'b0, PAT_ONES);
      // single word at the top address, clean pass
      retune(1'b1, 30'h3FFF_FFFF, 1'b1, 30'd1);
      queue_test(0);
      // a word count of zero runs one word; fault on the third compare
      retune(1'b0, '0, 1'b1, 30'd0);
      queue_test(3);

      test_no = 0;
      while (items_queued < ITEM_BUDGET) begin
         if (test_no == 1) begin
            retune(1'b1, 30'd0, 1'b1, 30'd256);
            fault_at = $urandom_range(1, 3);
         end else if (test_no == 4) begin
            // count above the backup depth clamps; region wraps past the top
            retune(1'b1, 30'h3FFF_FF80, 1'b1, 30'd257 + 30'($urandom_range(0, 254)));
            fault_at = $urandom_range(1, 3);
         end else begin
            if (eff_words(PLAN) > 40 || $urandom_range(0, 2) == 0) begin
               wr_base  = $urandom_range(0, 3) != 0;
               wr_words = !wr_base || eff_words(PLAN) > 40 || $urandom_range(0, 3) != 0;
               case ($urandom_range(0, 3))
                  0:       base = '0;
                  1:       base = 30'h3FFF_FFFF - 30'($urandom_range(0, 15));
                  default: base = 30'($urandom);
               endcase
               case ($urandom_range(0, 15))
                  0:       cnt = 9'd0;
                  1, 2:    cnt = 9'($urandom_range(11, 40));
                  default: cnt = 9'($urandom_range(1, 10));
               endcase
               // upper data bits are don't-care for the word count
               wv = 30'($urandom);
               wv[WCFG_W-1:0] = cnt;
               retune(wr_base, base, wr_words, wv);
            end
            fault_at = ($urandom_range(0, 4) < 2) ? $urandom_range(1, 5 * eff_words(PLAN)) : 0;
         end
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) offer(1'b0, $urandom);
         queue_test(fault_at);
         test_no++;
      end

      wait_drained(TAIL_CYCLES);
      $display("Ran %0d March C- tests, %0d of them ending on a miscompare", tests_done,
               tests_flagged);
      $display("%0d request beats driven, %0d response beats checked", req_beats,
               rsp_checked);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
